// ===== design/vt44_pkg.sv =====
// Shared types and constants for the 4x4 vertex transform.
// Used by vt44_lane, vt44_merge and vertex_transform_4x4.
package vt44_pkg;

  localparam int DIM      = 4;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int IDX_W    = 2;
  localparam int S_DATA_W = 168;
  localparam int M_DATA_W = DIM * DATA_W;

  localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_t;

  typedef logic [DATA_W-1:0] word_t;
  typedef word_t [DIM-1:0]   row_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef sum_t [DIM-1:0]    sum_arr_t;

  typedef struct packed {
    logic prod;
    logic sum;
  } stage_en_t;

endpackage

// ===== design/vt44_lane.sv =====
// One row lane: four 32x32 products registered, then their full-precision sum registered.
// Depends on vt44_pkg.
module vt44_lane (
  input  logic                clk,
  input  vt44_pkg::stage_en_t en,
  input  vt44_pkg::row_t      row,
  input  vt44_pkg::row_t      vec,
  output vt44_pkg::sum_t      sum
);
  import vt44_pkg::*;

  logic signed [PROD_W-1:0] prod [DIM];
  sum_t                     total;

  always_comb begin
    total = '0;
    for (int i = 0; i < DIM; i++) begin
      total = total + {{(SUM_W-PROD_W){prod[i][PROD_W-1]}}, prod[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en.prod) begin
      for (int i = 0; i < DIM; i++) begin
        prod[i] <= $signed(row[i]) * $signed(vec[i]);
      end
    end
    if (en.sum) begin
      sum <= total;
    end
  end

endmodule

// ===== design/vt44_merge.sv =====
// Merge stage: shift each lane sum down by FRAC_BITS, saturate to 32 bits, combine overflow.
// Depends on vt44_pkg.
module vt44_merge #(
  parameter int FRAC_BITS = 16
) (
  input  vt44_pkg::sum_arr_t sums,
  output vt44_pkg::row_t     comps,
  output logic               overflow
);
  import vt44_pkg::*;

  logic signed [SUM_W-1:0] shifted [DIM];
  logic [DIM-1:0]          sat;

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      shifted[i] = $signed(sums[i]) >>> FRAC_BITS;
      sat[i] = !((&shifted[i][SUM_W-1:DATA_W-1]) || !(|shifted[i][SUM_W-1:DATA_W-1]));
      if (sat[i]) begin
        comps[i] = shifted[i][SUM_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
        comps[i] = shifted[i][DATA_W-1:0];
      end
    end
    overflow = |sat;
  end

endmodule

// ===== design/vertex_transform_4x4.sv =====
// Top level of the 4x4 vertex transform: matrix store, four row lanes, merge and output register.
// Depends on vt44_pkg, vt44_lane and vt44_merge.
//
// Usage:
//   Input stream s_axis: tuser is the command. A write command stores entry_value at
//   (row_index, col_index) of the matrix and yields no output transfer. A transform
//   command multiplies the matrix by (vec_x, vec_y, vec_z, vec_w).
//   Output stream m_axis: tdata carries out_x..out_w, tuser the overflow flag, set when
//   any component saturated.
//   Pipeline: a transform result passes the product register, sum register and output
//   register in turn. Throughput: one item per cycle while m_axis_tready stays high,
//   set by the four row lanes of four 32x32 multipliers each working in parallel.
//   A write takes effect for a transform accepted on the very next cycle.
//   Reset: the matrix returns to identity (1.0 as 1 << FRAC_BITS on the diagonal),
//   all pipeline stages empty.
//   Stall: when the receiver holds m_axis_tready low the result stays; empty stages
//   behind it still fill, and s_axis_tready drops once all three stages hold data.
module vertex_transform_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // row_index, col_index, entry_value, vec_x, vec_y, vec_z, vec_w, zero pad
  input  logic [vt44_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // cmd
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_x, out_y, out_z, out_w
  output logic [vt44_pkg::M_DATA_W-1:0]     m_axis_tdata,
  // overflow
  output logic                              m_axis_tuser
);
  import vt44_pkg::*;

  localparam logic [DATA_W-1:0] ONE_FIX = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  row_t              matrix [DIM];
  logic [IDX_W-1:0]  row_index;
  logic [IDX_W-1:0]  col_index;
  word_t             entry_value;
  row_t              vec;
  logic              s_acc;
  logic              xform_acc;
  logic              v1;
  logic              v2;
  logic              ready_out;
  logic              adv_sum;
  logic              adv_prod;
  stage_en_t         lane_en;
  sum_arr_t          sums;
  row_t              comps;
  logic              sat_any;

  assign row_index   = s_axis_tdata[1:0];
  assign col_index   = s_axis_tdata[3:2];
  assign entry_value = s_axis_tdata[35:4];
  assign vec[0]      = s_axis_tdata[67:36];
  assign vec[1]      = s_axis_tdata[99:68];
  assign vec[2]      = s_axis_tdata[131:100];
  assign vec[3]      = s_axis_tdata[163:132];

  assign ready_out     = !m_axis_tvalid || m_axis_tready;
  assign adv_sum       = !v2 || ready_out;
  assign adv_prod      = !v1 || adv_sum;
  assign s_axis_tready = adv_prod;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign xform_acc     = s_acc && (s_axis_tuser == CMD_XFORM);

  assign lane_en.prod = xform_acc;
  assign lane_en.sum  = adv_sum && v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          matrix[r][c] <= (r == c) ? ONE_FIX : '0;
        end
      end
    end else if (s_acc && (s_axis_tuser == CMD_WRITE)) begin
      matrix[row_index][col_index] <= entry_value;
    end
  end

  genvar g;
  generate
    for (g = 0; g < DIM; g++) begin : g_lane
      vt44_lane u_lane (
        .clk (clk),
        .en  (lane_en),
        .row (matrix[g]),
        .vec (vec),
        .sum (sums[g])
      );
    end
  endgenerate

  vt44_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .sums     (sums),
    .comps    (comps),
    .overflow (sat_any)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (adv_prod) begin
        v1 <= xform_acc;
      end
      if (adv_sum) begin
        v2 <= v1;
      end
      if (ready_out) begin
        m_axis_tvalid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && v2) begin
      m_axis_tdata <= comps;
      m_axis_tuser <= sat_any;
    end
  end

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (s_axis_tuser == CMD_WRITE)) |=> !v1)
    else $error("write command entered the pipeline");

  a_xform_enters: assert property (@(posedge clk) disable iff (rst)
    xform_acc |=> v1)
    else $error("transform command lost at entry");

  a_overflow_sat: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[31:0] == WORD_MAX || m_axis_tdata[31:0] == WORD_MIN ||
       m_axis_tdata[63:32] == WORD_MAX || m_axis_tdata[63:32] == WORD_MIN ||
       m_axis_tdata[95:64] == WORD_MAX || m_axis_tdata[95:64] == WORD_MIN ||
       m_axis_tdata[127:96] == WORD_MAX || m_axis_tdata[127:96] == WORD_MIN))
    else $error("overflow flagged without a saturated component");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !v1 && !v2))
    else $error("pipeline not empty after reset");

endmodule
